// ===== design/pcx_rle_pkg.sv =====
package pcx_rle_pkg;

  // field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned BPL_W   = 16;
  localparam int unsigned PLN_W   = 3;
  localparam int unsigned LIN_W   = 16;
  localparam int unsigned PROD_W  = BPL_W + PLN_W;
  localparam int unsigned TOTAL_W = PROD_W + LIN_W;
  localparam int unsigned SHORT_W = 34;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DATA_W  = 16;

  // run code marker: both top bits set
  localparam logic [1:0] RUN_MARK = 2'b11;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BYTES_PER_LINE = 2'd0;
  localparam logic [IDX_W-1:0] REG_PLANE_COUNT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_LINE_COUNT     = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic use_input;
    logic accept;
    logic step;
    logic emit_byte;
    logic emit_rep;
    logic last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cnt_nz;
    logic eod;
    logic avail;
    logic more_bytes;
    logic recalc;
  } sts_t;

endpackage

// ===== design/pcx_rle_code_if.sv =====
interface pcx_rle_code_if;
  logic                               valid;
  logic                               ready;
  logic [pcx_rle_pkg::CODE_W-1:0]     code_byte;
  logic                               end_of_data;

  modport source (output valid, code_byte, end_of_data, input ready);
  modport sink (input valid, code_byte, end_of_data, output ready);
endinterface

// ===== design/pcx_rle_pixel_if.sv =====
interface pcx_rle_pixel_if;
  logic                               valid;
  logic                               ready;
  logic [pcx_rle_pkg::CODE_W-1:0]     pixel_byte;
  logic                               last_of_item;
  logic                               end_report;
  logic [pcx_rle_pkg::SHORT_W-1:0]    short_count;

  modport source (output valid, pixel_byte, last_of_item, end_report, short_count,
                  input ready);
  modport sink (input valid, pixel_byte, last_of_item, end_report, short_count,
                output ready);
endinterface

// ===== design/pcx_rle_cfg_if.sv =====
interface pcx_rle_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pcx_rle_pkg::IDX_W-1:0]      reg_index;
  logic [pcx_rle_pkg::DATA_W-1:0]     reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// ===== design/pcx_rle_dp.sv =====
module pcx_rle_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [pcx_rle_pkg::CODE_W-1:0]      code_byte,
  input  logic                                end_of_data,
  input  logic                                cfg_we,
  input  logic [pcx_rle_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pcx_rle_pkg::DATA_W-1:0]      cfg_data,
  input  pcx_rle_pkg::cmd_t                   cmd,
  output pcx_rle_pkg::sts_t                   sts,
  output logic [pcx_rle_pkg::CODE_W-1:0]      pixel_byte,
  output logic                                last_of_item,
  output logic                                end_report,
  output logic [pcx_rle_pkg::SHORT_W-1:0]     short_count
);

  // configuration registers
  logic [pcx_rle_pkg::BPL_W-1:0]   bytes_per_line;
  logic [pcx_rle_pkg::PLN_W-1:0]   plane_count;
  logic [pcx_rle_pkg::LIN_W-1:0]   line_count;

  // total recompute pipeline
  logic [1:0]                       rc;
  logic [pcx_rle_pkg::PROD_W-1:0]   prod;
  logic [pcx_rle_pkg::TOTAL_W-1:0]  total;

  // decode state
  logic                             run_pending;
  logic [pcx_rle_pkg::RUN_W-1:0]    run_length;
  logic [pcx_rle_pkg::TOTAL_W-1:0]  bytes_emitted;
  logic [pcx_rle_pkg::TOTAL_W-1:0]  left;

  // current request under work
  logic [pcx_rle_pkg::RUN_W-1:0]    work_count;
  logic [pcx_rle_pkg::CODE_W-1:0]   work_value;
  logic                             work_eod;

  logic                             in_is_run;
  logic [pcx_rle_pkg::RUN_W-1:0]    cur_count;
  logic [pcx_rle_pkg::CODE_W-1:0]   cur_value;
  logic                             cur_eod;
  logic [pcx_rle_pkg::RUN_W-1:0]    rem_count;

  // select incoming request or held work
  always_comb begin
    in_is_run = (code_byte[pcx_rle_pkg::CODE_W-1 -: 2] == pcx_rle_pkg::RUN_MARK);
    if (cmd.use_input) begin
      if (run_pending) begin
        cur_count = run_length;
      end else if (in_is_run) begin
        cur_count = '0;
      end else begin
        cur_count = pcx_rle_pkg::RUN_W'(1);
      end
      cur_value = code_byte;
      cur_eod   = end_of_data;
    end else begin
      cur_count = work_count;
      cur_value = work_value;
      cur_eod   = work_eod;
    end
    rem_count = cur_count - pcx_rle_pkg::RUN_W'(1);
  end

  // status to controller
  always_comb begin
    sts.cnt_nz     = (cur_count != '0);
    sts.eod        = cur_eod;
    sts.avail      = (left != '0);
    sts.more_bytes = (rem_count != '0) && (left[pcx_rle_pkg::TOTAL_W-1:1] != '0);
    sts.recalc     = (rc != 2'd0);
  end

  // config writes and total recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_line <= '0;
      plane_count    <= pcx_rle_pkg::PLN_W'(1);
      line_count     <= pcx_rle_pkg::LIN_W'(1);
      rc             <= 2'd0;
      prod           <= '0;
      total          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pcx_rle_pkg::REG_BYTES_PER_LINE: bytes_per_line <= cfg_data;
          pcx_rle_pkg::REG_PLANE_COUNT:    plane_count <= cfg_data[pcx_rle_pkg::PLN_W-1:0];
          pcx_rle_pkg::REG_LINE_COUNT:     line_count <= cfg_data[pcx_rle_pkg::LIN_W-1:0];
          default: ;
        endcase
        rc <= 2'd3;
      end else if (rc != 2'd0) begin
        rc <= rc - 2'd1;
      end
      if (rc != 2'd0) begin
        prod  <= pcx_rle_pkg::PROD_W'(bytes_per_line) *
                 pcx_rle_pkg::PROD_W'(plane_count);
        total <= pcx_rle_pkg::TOTAL_W'(prod) *
                 pcx_rle_pkg::TOTAL_W'(line_count);
      end
    end
  end

  // run parsing and byte accounting
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pending   <= 1'b0;
      run_length    <= '0;
      bytes_emitted <= '0;
      left          <= '0;
    end else begin
      if (cmd.accept) begin
        if (run_pending) begin
          run_pending <= 1'b0;
          run_length  <= '0;
        end else if (in_is_run && !end_of_data) begin
          run_pending <= 1'b1;
          run_length  <= code_byte[pcx_rle_pkg::RUN_W-1:0];
        end
      end
      if (rc != 2'd0) begin
        left <= (total > bytes_emitted) ? total - bytes_emitted : '0;
      end else if (cmd.emit_byte) begin
        bytes_emitted <= bytes_emitted + pcx_rle_pkg::TOTAL_W'(1);
        left          <= left - pcx_rle_pkg::TOTAL_W'(1);
      end else if (cmd.emit_rep) begin
        bytes_emitted <= '0;
        left          <= total;
      end
    end
  end

  // held work and output payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      work_count <= rem_count;
      work_value <= cur_value;
      work_eod   <= cur_eod;
    end
    if (cmd.emit_byte) begin
      pixel_byte   <= cur_value;
      last_of_item <= cmd.last;
      end_report   <= 1'b0;
      short_count  <= '0;
    end else if (cmd.emit_rep) begin
      pixel_byte   <= '0;
      last_of_item <= 1'b1;
      end_report   <= 1'b1;
      short_count  <= left[pcx_rle_pkg::TOTAL_W-1] ? '1 : left[pcx_rle_pkg::SHORT_W-1:0];
    end
  end

  // remaining count tracks the total once settled
  a_left_sum: assert property (@(posedge clk) disable iff (rst)
    (rc == 2'd0 && bytes_emitted <= total) |->
      ({1'b0, bytes_emitted} + {1'b0, left} == {1'b0, total}))
    else $error("remaining count out of step with emitted bytes");

  // a report never claims more missing bytes than the total
  a_short_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_rep && rc == 2'd0 |-> left <= total)
    else $error("missing count exceeds total");

  // the end report starts a fresh image
  a_rep_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_rep && rc == 2'd0 |=> (bytes_emitted == '0 && left == total))
    else $error("byte count not restarted after end report");

endmodule

// ===== design/pcx_rle_ctrl.sv =====
module pcx_rle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcx_rle_pkg::sts_t sts,
  output pcx_rle_pkg::cmd_t cmd
);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t state;
  logic   out_free;
  logic   more;

  // handshake and step commands
  always_comb begin
    out_free      = !out_valid || out_ready;
    in_ready      = (state == S_IDLE) && out_free && !sts.recalc;
    cmd.use_input = (state == S_IDLE);
    cmd.accept    = in_valid && in_ready;
    cmd.step      = cmd.accept || ((state == S_BUSY) && out_free);
    cmd.emit_byte = cmd.step && sts.cnt_nz && sts.avail;
    cmd.emit_rep  = cmd.step && !(sts.cnt_nz && sts.avail) && sts.eod;
    more          = cmd.emit_byte && (sts.more_bytes || sts.eod);
    cmd.last      = !more;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        state <= more ? S_BUSY : S_IDLE;
      end
      if (cmd.emit_byte || cmd.emit_rep) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a busy step always produces a result
  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && out_free) |-> (cmd.emit_byte || cmd.emit_rep))
    else $error("busy step produced no result");

  // the end report closes the request
  a_rep_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_rep |=> state == S_IDLE)
    else $error("end report did not finish the request");

  // no new request taken while busy or recalculating
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (state == S_IDLE && !sts.recalc))
    else $error("request taken while busy or recalculating");

endmodule

// ===== design/pcx_rle_byte_decoder_unit.sv =====
// channel | modport | payload                                           | request moves
// code    | sink    | code_byte[7:0], end_of_data                       | one source byte
// pixel   | source  | pixel_byte[7:0], last_of_item, end_report,
//         |         | short_count[33:0]                                 | one decoded byte/report
// cfg     | sink    | reg_index[1:0], reg_data[15:0]                    | one register write
//
// literal bytes pass at one per cycle while pixel is not stalled; a run emits up to 63 copies,
// all through the single output register that the controller refills.
// after each config write the total (two registered multiplies) and remaining
// count are recomputed, while code.ready stays low; cfg.ready is always high.
// rst is synchronous and active high; a stall on pixel holds the result and code.ready.
module pcx_rle_byte_decoder_unit (
  input logic            clk,
  input logic            rst,
  pcx_rle_code_if.sink   code,
  pcx_rle_pixel_if.source pixel,
  pcx_rle_cfg_if.sink    cfg
);

  pcx_rle_pkg::cmd_t cmd;
  pcx_rle_pkg::sts_t sts;

  // config port takes a write every cycle
  assign cfg.ready = 1'b1;

  // sequencing control
  pcx_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (code.valid),
    .in_ready  (code.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // decode datapath
  pcx_rle_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .code_byte    (code.code_byte),
    .end_of_data  (code.end_of_data),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.reg_index),
    .cfg_data     (cfg.reg_data),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_byte   (pixel.pixel_byte),
    .last_of_item (pixel.last_of_item),
    .end_report   (pixel.end_report),
    .short_count  (pixel.short_count)
  );

endmodule
